[rtl/indexed_min_heap_open_list_macros.svh]
// Assertion macros shared by the open list RTL.
`ifndef INDEXED_MIN_HEAP_OPEN_LIST_MACROS_SVH
`define INDEXED_MIN_HEAP_OPEN_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IMHOL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("open list check failed");

// Next-cycle implication, checked out of reset.
`define IMHOL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("open list check failed");

`endif

[rtl/imhol_pkg.sv]
// Types, codes and constants of the open list.
`default_nettype none
package imhol_pkg;
    localparam int LIST_DEPTH_DEF = 1024;
    localparam int MAX_NODES_DEF  = 4096;

    localparam int NODE_W   = 12;
    localparam int KEY_W    = 32;
    localparam int PARENT_W = 13;
    localparam int LINK_W   = 16;
    localparam int GATE_W   = 16;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int NCNT_W   = 13;
    localparam int PADDR_W  = 3;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 144;

    localparam logic [FUNC_W-1:0] FUNC_INSERT      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_VISITED = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd4;

    localparam logic [PADDR_W-1:0] REG_NODE_COUNT = 3'd0;
    localparam logic [NCNT_W-1:0]  NODE_COUNT_RST = 13'd4096;

    localparam logic [KEY_W-1:0]    KEY_NEVER     = 32'd409600000;
    localparam logic [LINK_W-1:0]   LINK_NONE     = 16'hFFFF;
    localparam logic [PARENT_W-1:0] PARENT_NONE   = 13'h1FFF;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    cost;
        logic [PARENT_W-1:0] parent;
        logic [LINK_W-1:0]   link;
        logic [2*GATE_W-1:0] gates;
        logic                visited;
    } entry_t;
endpackage
`default_nettype wire

[rtl/indexed_min_heap_open_list.sv]
// Top level of the open list: indexed binary min-heap with decrease-key.
`default_nettype none
// Open list of a path search. Each beat on the s_ side carries one operation
// (insert-or-decrease, extract-min, query, set-visited, clear-used) and yields
// exactly one result beat on the m_ side, with the status and the entry of the
// reported node as it stands after the operation. Entries live in one list RAM
// (heap at the low positions, closed entries packed down from the top), and a
// second RAM maps each node to its list position with a valid bit. Both RAMs
// have a single read port with a registered read, so each heap level of a
// sift passes through S_UP and S_UP_CMP going up, and through S_DN, S_DN_C1,
// S_DN_C2 (only when a right child exists) and S_DN_DEC going down; clear-used
// reads and clears the map slot of each used entry in turn. Every operation
// also passes through dispatch and report. One operation is in flight at a
// time; the next beat is taken as soon as the result has moved to the output
// register, even while that register still waits for m_tready. After reset
// the node map is swept clear, one entry per cycle across min(MAX_NODES, 4096)
// entries, during which s_tready stays low; APB writes are taken always.
module indexed_min_heap_open_list #(
    parameter int LIST_DEPTH = imhol_pkg::LIST_DEPTH_DEF,
    parameter int MAX_NODES  = imhol_pkg::MAX_NODES_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // s_tdata: node[11:0], parent_node[24:12], link_index[40:25], gate_a[56:41],
    //          gate_b[72:57], key_in[104:73], cost_in[136:105], visited_in[137]
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [imhol_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: func[2:0]
    input  wire [imhol_pkg::FUNC_W-1:0]    s_tuser,
    // m_tdata: node_out[11:0], known[12], key_out[44:13], cost_out[76:45],
    //          link_out[92:77], visited_out[93], parent_out[106:94],
    //          gate_a_out[122:107], gate_b_out[138:123]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [imhol_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [imhol_pkg::STATUS_W-1:0] m_tuser,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [imhol_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                     pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import imhol_pkg::*;

    `include "indexed_min_heap_open_list_macros.svh"

    localparam int PW        = $clog2(LIST_DEPTH);
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int MAP_DEPTH = (MAX_NODES < 4096) ? MAX_NODES : 4096;
    localparam int MAW       = $clog2(MAP_DEPTH);
    localparam int MAPW      = PW + 1;
    localparam int EW        = $bits(entry_t);

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_INS_MAP  = 5'd3;
    localparam logic [4:0] S_INS_ENT  = 5'd4;
    localparam logic [4:0] S_UP       = 5'd5;
    localparam logic [4:0] S_UP_CMP   = 5'd6;
    localparam logic [4:0] S_EXT_TOP  = 5'd7;
    localparam logic [4:0] S_EXT_LAST = 5'd8;
    localparam logic [4:0] S_DN       = 5'd9;
    localparam logic [4:0] S_DN_C1    = 5'd10;
    localparam logic [4:0] S_DN_C2    = 5'd11;
    localparam logic [4:0] S_DN_DEC   = 5'd12;
    localparam logic [4:0] S_SV_MAP   = 5'd13;
    localparam logic [4:0] S_SV_ENT   = 5'd14;
    localparam logic [4:0] S_CLR_RD   = 5'd15;
    localparam logic [4:0] S_CLR_WR   = 5'd16;
    localparam logic [4:0] S_RPT      = 5'd17;
    localparam logic [4:0] S_RPT_MAP  = 5'd18;
    localparam logic [4:0] S_RPT_ENT  = 5'd19;
    localparam logic [4:0] S_OUT      = 5'd20;

    localparam entry_t ENTRY_NONE = '{
        node: '0, key: KEY_NEVER, cost: KEY_NEVER, parent: PARENT_NONE,
        link: LINK_NONE, gates: '0, visited: 1'b0
    };

    logic [NCNT_W-1:0] node_count;

    imhol_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_count (node_count)
    );

    // List RAM and node map RAM
    logic            ent_we;
    logic [PW-1:0]   ent_waddr;
    entry_t          ent_wdata;
    logic [PW-1:0]   ent_raddr;
    entry_t          ent_rdata;
    logic [EW-1:0]   ent_rdata_raw;
    logic            map_we;
    logic [MAW-1:0]  map_waddr;
    logic [MAPW-1:0] map_wdata;
    logic [MAW-1:0]  map_raddr;
    logic [MAPW-1:0] map_rdata;

    imhol_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_list_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata_raw)
    );
    assign ent_rdata = entry_t'(ent_rdata_raw);

    imhol_ram #(.WIDTH(MAPW), .DEPTH(MAP_DEPTH)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Control and working registers
    logic [4:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic                vin_reg, vin_next;
    entry_t              new_reg, new_next;
    entry_t              mov_reg, mov_next;
    entry_t              cand_reg, cand_next;
    entry_t              rep_reg, rep_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       cpos_reg, cpos_next;
    logic [CW-1:0]       open_reg, open_next;
    logic [CW-1:0]       closed_reg, closed_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [MAW-1:0]      init_reg, init_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [NODE_W-1:0]   rnode_reg, rnode_next;
    logic                known_reg, known_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    logic [CW-1:0]   used_count;
    logic [CW-1:0]   gap;
    logic [CW-1:0]   closed_inc;
    logic [PW+1:0]   c1;
    logic [PW+1:0]   c2;
    logic [PW-1:0]   up_pos;
    logic            map_valid;
    logic [PW-1:0]   map_pos;

    function automatic logic node_in_range(input logic [NODE_W-1:0] n,
                                           input logic [NCNT_W-1:0] cnt);
        node_in_range = ({1'b0, n} < cnt) && (32'(n) < 32'(MAX_NODES));
    endfunction

    function automatic logic node_mapped(input logic [NODE_W-1:0] n);
        node_mapped = 32'(n) < 32'(MAP_DEPTH);
    endfunction

    assign used_count = open_reg + closed_reg;
    assign gap        = CW'(LIST_DEPTH) - used_count;
    assign closed_inc = closed_reg + CW'(1);
    assign c1         = {1'b0, pos_reg, 1'b1};
    assign c2         = c1 + (PW+2)'(1);
    assign up_pos     = (pos_reg - PW'(1)) >> 1;
    assign map_valid  = map_rdata[PW];
    assign map_pos    = map_rdata[PW-1:0];

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        node_next    = node_reg;
        vin_next     = vin_reg;
        new_next     = new_reg;
        mov_next     = mov_reg;
        cand_next    = cand_reg;
        rep_next     = rep_reg;
        pos_next     = pos_reg;
        cpos_next    = cpos_reg;
        open_next    = open_reg;
        closed_next  = closed_reg;
        idx_next     = idx_reg;
        init_next    = init_reg;
        status_next  = status_reg;
        rnode_next   = rnode_reg;
        known_next   = known_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        ent_we    = 1'b0;
        ent_waddr = pos_reg;
        ent_wdata = mov_reg;
        ent_raddr = '0;
        map_we    = 1'b0;
        map_waddr = mov_reg.node[MAW-1:0];
        map_wdata = {1'b1, pos_reg};
        map_raddr = '0;

        // Drop the result beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                // Sweep the node map clear after reset
                map_we    = 1'b1;
                map_waddr = init_reg;
                map_wdata = '0;
                init_next = init_reg + MAW'(1);
                if (init_reg == MAW'(MAP_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next          = s_tuser;
                    node_next          = s_tdata[11:0];
                    new_next.node      = s_tdata[11:0];
                    new_next.parent    = s_tdata[24:12];
                    new_next.link      = s_tdata[40:25];
                    new_next.gates     = {s_tdata[72:57], s_tdata[56:41]};
                    new_next.key       = s_tdata[104:73];
                    new_next.cost      = s_tdata[136:105];
                    new_next.visited   = 1'b0;
                    vin_next           = s_tdata[137];
                    state_next         = S_DISP;
                end
            end
            S_DISP: begin
                rnode_next  = node_reg;
                status_next = STATUS_OK;
                map_raddr   = node_reg[MAW-1:0];
                unique case (func_reg)
                    FUNC_INSERT: begin
                        if (!node_in_range(node_reg, node_count)) begin
                            status_next = STATUS_RANGE;
                            state_next  = S_RPT;
                        end else begin
                            state_next  = S_INS_MAP;
                        end
                    end
                    FUNC_EXTRACT: begin
                        ent_raddr = '0;
                        if (open_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = S_RPT;
                        end else begin
                            state_next  = S_EXT_TOP;
                        end
                    end
                    FUNC_SET_VISITED: begin
                        if (!node_in_range(node_reg, node_count)) begin
                            status_next = STATUS_RANGE;
                            state_next  = S_RPT;
                        end else begin
                            state_next  = S_SV_MAP;
                        end
                    end
                    FUNC_CLEAR: begin
                        idx_next = '0;
                        if (used_count == '0) begin
                            state_next = S_RPT;
                        end else begin
                            state_next = S_CLR_RD;
                        end
                    end
                    default: begin
                        // Query, and any unused code behaves as one
                        if (!node_in_range(node_reg, node_count)) begin
                            status_next = STATUS_RANGE;
                        end
                        state_next = S_RPT;
                    end
                endcase
            end
            S_INS_MAP: begin
                if (map_valid) begin
                    if ({1'b0, map_pos} >= (PW+1)'(open_reg)) begin
                        // Closed node: no decrease from the tail
                        status_next = STATUS_DROPPED;
                        state_next  = S_RPT;
                    end else begin
                        ent_raddr  = map_pos;
                        pos_next   = map_pos;
                        state_next = S_INS_ENT;
                    end
                end else if (used_count >= CW'(LIST_DEPTH)) begin
                    status_next = STATUS_FULL;
                    state_next  = S_RPT;
                end else begin
                    mov_next   = new_reg;
                    pos_next   = open_reg[PW-1:0];
                    open_next  = open_reg + CW'(1);
                    state_next = S_UP;
                end
            end
            S_INS_ENT: begin
                if (ent_rdata.key <= new_reg.key) begin
                    status_next = STATUS_DROPPED;
                    state_next  = S_RPT;
                end else begin
                    mov_next         = new_reg;
                    mov_next.node    = ent_rdata.node;
                    mov_next.visited = ent_rdata.visited;
                    state_next       = S_UP;
                end
            end
            S_UP: begin
                ent_raddr = up_pos;
                if (pos_reg == '0) begin
                    ent_we     = 1'b1;
                    map_we     = node_mapped(mov_reg.node);
                    state_next = S_RPT;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ent_we = 1'b1;
                if (ent_rdata.key < mov_reg.key) begin
                    // Parent strictly lower: settle here
                    map_we     = node_mapped(mov_reg.node);
                    state_next = S_RPT;
                end else begin
                    // Pull the parent down one level
                    ent_wdata  = ent_rdata;
                    map_we     = node_mapped(ent_rdata.node);
                    map_waddr  = ent_rdata.node[MAW-1:0];
                    pos_next   = up_pos;
                    state_next = S_UP;
                end
            end
            S_EXT_TOP: begin
                // Move the minimum to the closed tail
                ent_we      = 1'b1;
                ent_waddr   = PW'(CW'(LIST_DEPTH) - closed_inc);
                ent_wdata   = ent_rdata;
                map_we      = node_mapped(ent_rdata.node);
                map_waddr   = ent_rdata.node[MAW-1:0];
                map_wdata   = {1'b1, PW'(CW'(LIST_DEPTH) - closed_inc)};
                closed_next = closed_inc;
                open_next   = open_reg - CW'(1);
                rnode_next  = ent_rdata.node;
                mov_next    = ent_rdata;
                ent_raddr   = PW'(open_reg - CW'(1));
                if (open_reg == CW'(1)) begin
                    state_next = S_RPT;
                end else begin
                    state_next = S_EXT_LAST;
                end
            end
            S_EXT_LAST: begin
                // On a full list the last heap slot is the tail slot just
                // written, so the minimum itself is what moves to the root
                if (used_count != CW'(LIST_DEPTH)) begin
                    mov_next = ent_rdata;
                end
                pos_next   = '0;
                state_next = S_DN;
            end
            S_DN: begin
                ent_raddr = c1[PW-1:0];
                if (c1 >= (PW+2)'(open_reg)) begin
                    ent_we     = 1'b1;
                    map_we     = node_mapped(mov_reg.node);
                    state_next = S_RPT;
                end else begin
                    state_next = S_DN_C1;
                end
            end
            S_DN_C1: begin
                cand_next = ent_rdata;
                cpos_next = c1[PW-1:0];
                ent_raddr = c2[PW-1:0];
                if (c2 < (PW+2)'(open_reg)) begin
                    state_next = S_DN_C2;
                end else begin
                    state_next = S_DN_DEC;
                end
            end
            S_DN_C2: begin
                // Right child only when strictly lower
                if (ent_rdata.key < cand_reg.key) begin
                    cand_next = ent_rdata;
                    cpos_next = c2[PW-1:0];
                end
                state_next = S_DN_DEC;
            end
            S_DN_DEC: begin
                ent_we = 1'b1;
                if (cand_reg.key >= mov_reg.key) begin
                    map_we     = node_mapped(mov_reg.node);
                    state_next = S_RPT;
                end else begin
                    ent_wdata  = cand_reg;
                    map_we     = node_mapped(cand_reg.node);
                    map_waddr  = cand_reg.node[MAW-1:0];
                    pos_next   = cpos_reg;
                    state_next = S_DN;
                end
            end
            S_SV_MAP: begin
                ent_raddr = map_pos;
                pos_next  = map_pos;
                if (map_valid) begin
                    state_next = S_SV_ENT;
                end else begin
                    state_next = S_RPT;
                end
            end
            S_SV_ENT: begin
                ent_we            = 1'b1;
                ent_wdata         = ent_rdata;
                ent_wdata.visited = vin_reg;
                state_next        = S_RPT;
            end
            S_CLR_RD: begin
                // Open entries first, then the closed tail
                if (idx_reg < open_reg) begin
                    ent_raddr = idx_reg[PW-1:0];
                end else begin
                    ent_raddr = PW'(idx_reg + gap);
                end
                state_next = S_CLR_WR;
            end
            S_CLR_WR: begin
                map_we    = node_mapped(ent_rdata.node);
                map_waddr = ent_rdata.node[MAW-1:0];
                map_wdata = '0;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == used_count) begin
                    open_next   = '0;
                    closed_next = '0;
                    state_next  = S_RPT;
                end else begin
                    state_next  = S_CLR_RD;
                end
            end
            S_RPT: begin
                map_raddr  = rnode_reg[MAW-1:0];
                state_next = S_RPT_MAP;
            end
            S_RPT_MAP: begin
                ent_raddr = map_pos;
                if (node_in_range(rnode_reg, node_count) && map_valid) begin
                    state_next = S_RPT_ENT;
                end else begin
                    rep_next   = ENTRY_NONE;
                    known_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_RPT_ENT: begin
                rep_next   = ent_rdata;
                known_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {5'd0,
                                    rep_reg.gates[2*GATE_W-1:GATE_W],
                                    rep_reg.gates[GATE_W-1:0],
                                    rep_reg.parent,
                                    rep_reg.visited,
                                    rep_reg.link,
                                    rep_reg.cost,
                                    rep_reg.key,
                                    known_reg,
                                    rnode_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            init_reg    <= '0;
            open_reg    <= '0;
            closed_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            open_reg    <= open_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        node_reg   <= node_next;
        vin_reg    <= vin_next;
        new_reg    <= new_next;
        mov_reg    <= mov_next;
        cand_reg   <= cand_next;
        rep_reg    <= rep_next;
        pos_reg    <= pos_next;
        cpos_reg   <= cpos_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rnode_reg  <= rnode_next;
        known_reg  <= known_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Heap and closed tail never overlap
    `IMHOL_ASSERT_IMP(a_list_bound, 1'b1, used_count <= CW'(LIST_DEPTH))
    // No beat is taken during the map sweep
    `IMHOL_ASSERT_IMP(a_init_stall, state_reg == S_INIT, !s_tready)
    // An accepted beat always starts work
    `IMHOL_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state_reg == S_DISP)
    // A fresh result only appears after the report step
    `IMHOL_ASSERT_IMP(a_result_from_out, $rose(m_tvalid), $past(state_reg) == S_OUT)
endmodule
`default_nettype wire

[rtl/imhol_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none
module imhol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/imhol_cfg.sv]
// APB register slice holding the node count.
`default_nettype none
module imhol_cfg (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [imhol_pkg::PADDR_W-1:0] paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [imhol_pkg::NCNT_W-1:0] node_count
);
    import imhol_pkg::*;

    logic [NCNT_W-1:0] node_count_reg;
    logic [NCNT_W-1:0] node_count_next;

    always_comb begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && paddr == REG_NODE_COUNT) begin
            node_count_next = pwdata[NCNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
        end else begin
            node_count_reg <= node_count_next;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr == REG_NODE_COUNT) ? {{(32-NCNT_W){1'b0}}, node_count_reg} : 32'd0;
    assign node_count = node_count_reg;
endmodule
`default_nettype wire

[tb/indexed_min_heap_open_list_checker.sv]
// Checker of the open list: watches both streams and the APB port, predicts and compares.
module indexed_min_heap_open_list_checker
    import imhol_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    input  wire                  s_tready,
    input  wire [S_DATA_W-1:0]   s_tdata,
    input  wire [FUNC_W-1:0]     s_tuser,
    input  wire                  m_tvalid,
    input  wire                  m_tready,
    input  wire [M_DATA_W-1:0]   m_tdata,
    input  wire [STATUS_W-1:0]   m_tuser,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [PADDR_W-1:0]    paddr,
    input  wire [31:0]           pwdata,
    input  wire                  pready,
    output int                   fail_count,
    output int                   pending
);
    localparam int DEPTH = LIST_DEPTH_DEF;
    localparam int NODES = MAX_NODES_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NODE_W-1:0]   node;
        logic                known;
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    cost;
        logic [LINK_W-1:0]   link;
        logic                visited;
        logic [PARENT_W-1:0] parent;
        logic [GATE_W-1:0]   gate_a;
        logic [GATE_W-1:0]   gate_b;
    } outcome_t;

    entry_t         list_mem [DEPTH];
    int             node_pos [NODES];
    bit             node_seen [NODES];
    int             open_cnt;
    int             closed_cnt;
    logic [NCNT_W-1:0] node_count;
    outcome_t       outcome_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        open_cnt   = 0;
        closed_cnt = 0;
        node_count = NODE_COUNT_RST;
        foreach (node_seen[i]) node_seen[i] = 0;
    end

    function automatic int node_limit();
        return (int'(node_count) < NODES) ? int'(node_count) : NODES;
    endfunction

    function automatic void swap_slots(int a, int b);
        entry_t t;
        t = list_mem[a];
        list_mem[a] = list_mem[b];
        list_mem[b] = t;
        node_pos[list_mem[a].node] = a;
        node_seen[list_mem[a].node] = 1;
        node_pos[list_mem[b].node] = b;
        node_seen[list_mem[b].node] = 1;
    endfunction

    function automatic logic [STATUS_W-1:0] insert_node(int n, logic [S_DATA_W-1:0] d);
        int p;
        int up;
        logic [KEY_W-1:0] k;
        k = d[104:73];
        if (node_seen[n]) begin
            p = node_pos[n];
            if (p >= open_cnt) return STATUS_DROPPED;
            if (list_mem[p].key <= k) return STATUS_DROPPED;
        end else begin
            if (open_cnt + closed_cnt >= DEPTH) return STATUS_FULL;
            p = open_cnt;
            list_mem[p].node = n[NODE_W-1:0];
            list_mem[p].visited = 1'b0;
            node_pos[n] = p;
            node_seen[n] = 1;
            open_cnt++;
        end
        list_mem[p].key    = k;
        list_mem[p].cost   = d[136:105];
        list_mem[p].parent = d[24:12];
        list_mem[p].link   = d[40:25];
        list_mem[p].gates  = {d[72:57], d[56:41]};
        // climb past parents with an equal key
        while (p > 0) begin
            up = (p - 1) >> 1;
            if (list_mem[up].key < list_mem[p].key) break;
            swap_slots(up, p);
            p = up;
        end
        return STATUS_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] extract_top(inout int n);
        int dst;
        int par;
        int c1;
        int best;
        if (open_cnt == 0) return STATUS_EMPTY;
        closed_cnt++;
        n = list_mem[0].node;
        dst = DEPTH - closed_cnt;
        list_mem[dst] = list_mem[0];
        node_pos[n] = dst;
        open_cnt--;
        if (open_cnt != 0) begin
            list_mem[0] = list_mem[open_cnt];
            node_pos[list_mem[0].node] = 0;
        end
        par = 0;
        forever begin
            c1 = 2 * par + 1;
            if (c1 >= open_cnt) break;
            best = c1;
            if (c1 + 1 < open_cnt && list_mem[c1+1].key < list_mem[c1].key) best = c1 + 1;
            if (list_mem[best].key >= list_mem[par].key) break;
            swap_slots(best, par);
            par = best;
        end
        return STATUS_OK;
    endfunction

    function automatic outcome_t predict_result(logic [FUNC_W-1:0] func,
                                                logic [S_DATA_W-1:0] d);
        outcome_t r;
        int n;
        bit in_range;
        logic [STATUS_W-1:0] st;
        entry_t e;
        n = int'(d[11:0]);
        in_range = n < node_limit();
        st = STATUS_OK;
        case (func)
            FUNC_INSERT: st = in_range ? insert_node(n, d) : STATUS_RANGE;
            FUNC_EXTRACT: st = extract_top(n);
            FUNC_SET_VISITED: begin
                if (!in_range) st = STATUS_RANGE;
                else if (node_seen[n]) list_mem[node_pos[n]].visited = d[137];
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < open_cnt; i++) node_seen[list_mem[i].node] = 0;
                for (int i = 0; i < closed_cnt; i++)
                    node_seen[list_mem[DEPTH-1-i].node] = 0;
                open_cnt = 0;
                closed_cnt = 0;
            end
            default: st = in_range ? STATUS_OK : STATUS_RANGE;
        endcase
        r.status = st;
        r.node = n[NODE_W-1:0];
        if (n < node_limit() && node_seen[n]) begin
            e = list_mem[node_pos[n]];
            r.known = 1'b1;
            r.key = e.key;
            r.cost = e.cost;
            r.link = e.link;
            r.visited = e.visited;
            r.parent = e.parent;
            r.gate_a = e.gates[15:0];
            r.gate_b = e.gates[31:16];
        end else begin
            r.known = 1'b0;
            r.key = KEY_NEVER;
            r.cost = KEY_NEVER;
            r.link = LINK_NONE;
            r.visited = 1'b0;
            r.parent = PARENT_NONE;
            r.gate_a = '0;
            r.gate_b = '0;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing expected: status %0d node %0h",
                           m_tuser, m_tdata[11:0]);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status",      want.status,  m_tuser);
                    check_field("node_out",    want.node,    m_tdata[11:0]);
                    check_field("known",       want.known,   m_tdata[12]);
                    check_field("key_out",     want.key,     m_tdata[44:13]);
                    check_field("cost_out",    want.cost,    m_tdata[76:45]);
                    check_field("link_out",    want.link,    m_tdata[92:77]);
                    check_field("visited_out", want.visited, m_tdata[93]);
                    check_field("parent_out",  want.parent,  m_tdata[106:94]);
                    check_field("gate_a_out",  want.gate_a,  m_tdata[122:107]);
                    check_field("gate_b_out",  want.gate_b,  m_tdata[138:123]);
                end
            end
            if (s_tvalid && s_tready) outcome_q.push_back(predict_result(s_tuser, s_tdata));
            if (psel && penable && pwrite && pready && paddr == REG_NODE_COUNT)
                node_count = pwdata[NCNT_W-1:0];
            pending = outcome_q.size();
        end
    end
endmodule

[tb/indexed_min_heap_open_list_tb.sv]
// Stimulus and verdict for the open list, with the checker beside the block.
module indexed_min_heap_open_list_tb;
    import imhol_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    bit                  calm;     // no idling on either side while set
    int                  fresh_node;

    indexed_min_heap_open_list u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    indexed_min_heap_open_list_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hold the run to a fixed ceiling: far above the slowest legal run.
    initial begin
        #(8 * 1500000);
        $display("status: fail");
        $finish;
    end

    // Stall the result side at random, about 30 percent of the time, except in calm stretches.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Drive one beat: idle at random first, then hold tvalid until the beat is taken.
    task automatic send_beat(logic [FUNC_W-1:0] func, int node, logic [KEY_W-1:0] key,
                             logic [PARENT_W-1:0] parent, logic [LINK_W-1:0] link,
                             logic [GATE_W-1:0] ga, logic [GATE_W-1:0] gb,
                             logic [KEY_W-1:0] cost, logic vis);
        if (!calm && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 30) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, vis, cost, key, gb, ga, link, parent, node[NODE_W-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Fill the stored fields at random; parent is none about one time in ten.
    task automatic send_op(logic [FUNC_W-1:0] func, int node, logic [KEY_W-1:0] key);
        logic [PARENT_W-1:0] parent;
        parent = ($urandom_range(0, 9) == 0) ? PARENT_NONE : PARENT_W'($urandom_range(0, 4095));
        send_beat(func, node, key, parent, LINK_W'($urandom), GATE_W'($urandom),
                  GATE_W'($urandom), $urandom, 1'($urandom));
    endtask

    // Drop tvalid and wait until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        // narrow keys make ties common
        return ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 15)) : $urandom;
    endfunction

    // Mixed traffic over a small pool of nodes, some just beyond node_count.
    task automatic mixed_phase(int ncount, int items);
        int r;
        int n;
        logic [FUNC_W-1:0] f;
        apb_write(REG_NODE_COUNT, ncount);
        send_op(FUNC_CLEAR, $urandom_range(0, 4095), 0);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)      f = FUNC_INSERT;
            else if (r < 70) f = FUNC_EXTRACT;
            else if (r < 83) f = FUNC_QUERY;
            else if (r < 97) f = FUNC_SET_VISITED;
            else             f = FUNC_CLEAR;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, ncount + 2);
            if (n > 4095) n = 4095;
            send_op(f, n, pick_key());
        end
        drain();
    endtask

    initial begin
        int r;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_QUERY;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        calm     = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, field extremes, ties, drops, closed nodes, clear.
        send_op(FUNC_QUERY, 0, 0);
        send_op(FUNC_EXTRACT, 7, 0);
        send_op(FUNC_SET_VISITED, 9, 0);
        send_beat(FUNC_INSERT, 0, 32'hFFFF_FFFF, 13'd4095, 16'h7FFF, 16'h8000, 16'h7FFF,
                  32'hFFFF_FFFF, 1'b1);
        send_beat(FUNC_INSERT, 4095, 32'd0, PARENT_NONE, LINK_NONE, 16'hFFFF, 16'h0000,
                  32'd0, 1'b0);
        send_op(FUNC_INSERT, 12, 32'd0);
        send_op(FUNC_INSERT, 13, 32'd0);
        send_op(FUNC_INSERT, 14, 32'd5);
        send_op(FUNC_INSERT, 14, 32'd5);
        send_op(FUNC_INSERT, 14, 32'd6);
        send_op(FUNC_INSERT, 0, 32'd3);
        send_beat(FUNC_SET_VISITED, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_op(FUNC_QUERY, 0, 0);
        send_beat(FUNC_SET_VISITED, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_op(FUNC_EXTRACT, 0, 0);
        send_op(FUNC_EXTRACT, 0, 0);
        send_op(FUNC_EXTRACT, 0, 0);
        send_op(FUNC_INSERT, 4095, 32'd0);
        send_beat(FUNC_SET_VISITED, 4095, 0, 0, 0, 0, 0, 0, 1'b1);
        send_op(FUNC_QUERY, 4095, 0);
        send_op(FUNC_CLEAR, 4095, 0);
        send_op(FUNC_QUERY, 13, 0);
        drain();

        // Smallest node range: only node 0 is legal.
        apb_write(REG_NODE_COUNT, 1);
        send_op(FUNC_INSERT, 5, 32'd1);
        send_op(FUNC_QUERY, 5, 0);
        send_op(FUNC_SET_VISITED, 5, 0);
        send_op(FUNC_INSERT, 0, 32'd1);
        send_op(FUNC_QUERY, 0, 0);
        drain();

        // Fill the list to the brim with fresh nodes, then try closed and full cases.
        apb_write(REG_NODE_COUNT, 4096);
        send_op(FUNC_CLEAR, 0, 0);
        fresh_node = 0;
        while (fresh_node < 1030) begin
            r = $urandom_range(0, 99);
            if (r < 97) begin
                send_op(FUNC_INSERT, fresh_node, pick_key());
                fresh_node++;
            end else if (r < 99) begin
                send_op(FUNC_EXTRACT, 0, 0);
            end else begin
                send_op(FUNC_INSERT, $urandom_range(0, fresh_node), pick_key());
            end
        end
        send_op(FUNC_EXTRACT, 0, 0);
        send_op(FUNC_EXTRACT, 0, 0);
        for (int i = 0; i < 20; i++)
            send_op(($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_QUERY,
                    $urandom_range(0, 4095), pick_key());
        drain();

        mixed_phase(17, 45);
        calm = 1'b1;
        mixed_phase(300, 45);
        calm = 1'b0;
        mixed_phase(1, 25);
        mixed_phase(4096, 45);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
